// ===== rtl/nrs_pkg.sv =====
package nrs_pkg;

    localparam int DEF_BOARD_DEPTH    = 8;
    localparam int DEF_MAX_REQUESTERS = 16;
    localparam int DEF_VALUE_WIDTH    = 10;

    localparam int CAP_RESET = 8;
    localparam int REQ_RESET = 4;

    localparam logic CMD_POST   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_CAPACITY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUESTER_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        logic clear;
        logic valid;
        logic first_mode;
    } t_sel_ctl;

endpackage

// ===== rtl/nrs_select.sv =====
module nrs_select #(
    parameter int VALUE_WIDTH = nrs_pkg::DEF_VALUE_WIDTH,
    parameter int ID_W        = 4,
    parameter int IDX_W       = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  nrs_pkg::t_sel_ctl      i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [ID_W-1:0]        i_owner,
    input  logic [IDX_W-1:0]       i_index,
    input  logic [VALUE_WIDTH-1:0] i_last,
    output logic [IDX_W-1:0]       o_best_index,
    output logic [VALUE_WIDTH-1:0] o_best_value,
    output logic [ID_W-1:0]        o_best_owner
);
    import nrs_pkg::*;

    logic                   r_have;
    logic                   n_have;
    logic [VALUE_WIDTH-1:0] r_best_metric;
    logic [IDX_W-1:0]       r_best_index;
    logic [VALUE_WIDTH-1:0] r_best_value;
    logic [ID_W-1:0]        r_best_owner;
    logic [VALUE_WIDTH-1:0] metric;
    logic                   update;

    // Before the first serve the smallest value wins, afterwards the one nearest the
    // last served value. A strict compare keeps the earliest posted entry on a tie.
    always_comb begin
        if (i_ctl.first_mode) begin
            metric = i_value;
        end else if (i_value > i_last) begin
            metric = i_value - i_last;
        end else begin
            metric = i_last - i_value;
        end
        update = i_ctl.valid && (!r_have || (metric < r_best_metric));
        n_have = i_ctl.clear ? 1'b0 : (r_have | i_ctl.valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else begin
            r_have <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (update) begin
            r_best_metric <= metric;
            r_best_index  <= i_index;
            r_best_value  <= i_value;
            r_best_owner  <= i_owner;
        end
    end

    assign o_best_index = r_best_index;
    assign o_best_value = r_best_value;
    assign o_best_owner = r_best_owner;

endmodule

// ===== rtl/nearest_request_scheduler.sv =====
// Nearest-request scheduler: a board of pending requests, at most one per requester.
// A command word is taken at a rising edge where start is high and busy is low:
// i_cmd selects a post (i_requester_id, i_request_value) or a finish of i_requester_id.
// Every command word yields exactly one result word, shown for one cycle while
// o_result_strobe is high: the post status and, when the board reached its live
// capacity, the served requester and value. The receiver cannot stall, so the result
// is simply presented; busy falls in the same cycle and the next command may follow.
// When nothing is served, the word passes through the check state and the strobe is registered as it leaves it.
// A serve sweeps the board memory once to pick the entry and once more to close the
// gap it leaves, one read per cycle through its single read port.
// Configuration writes are taken in any cycle and are meant for idle periods; writing
// the requester count also reloads the active count.
// Reset empties the board, clears the pending flags, restores capacity 8 and four
// active requesters, and marks that nothing has been served yet. No clearing pass runs.
module nearest_request_scheduler #(
    parameter int  BOARD_DEPTH    = nrs_pkg::DEF_BOARD_DEPTH,
    parameter int  MAX_REQUESTERS = nrs_pkg::DEF_MAX_REQUESTERS,
    parameter int  VALUE_WIDTH    = nrs_pkg::DEF_VALUE_WIDTH,
    localparam int ID_W           = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1,
    localparam int CAP_W          = $clog2(BOARD_DEPTH + 1),
    localparam int CNT_W          = $clog2(MAX_REQUESTERS + 1),
    localparam int CFG_W          = (CAP_W > CNT_W) ? CAP_W : CNT_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cmd,
    input  logic [ID_W-1:0]                 i_requester_id,
    input  logic [VALUE_WIDTH-1:0]          i_request_value,
    input  logic                            i_cfg_we,
    input  logic [nrs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]                i_cfg_data,
    output logic                            o_result_strobe,
    output logic                            o_post_status,
    output logic                            o_served,
    output logic [ID_W-1:0]                 o_served_requester,
    output logic [VALUE_WIDTH-1:0]          o_served_value
);
    import nrs_pkg::*;

    localparam int IDX_W      = (BOARD_DEPTH > 1) ? $clog2(BOARD_DEPTH) : 1;
    localparam int PEND_N     = 1 << ID_W;
    localparam int WORD_W     = ID_W + VALUE_WIDTH;
    localparam int ACT_RESET  = (REQ_RESET > MAX_REQUESTERS) ? MAX_REQUESTERS : REQ_RESET;

    t_state                 r_state, n_state;
    logic [CAP_W-1:0]       r_cfg_cap, n_cfg_cap;
    logic [CNT_W-1:0]       r_active, n_active;
    logic [CAP_W-1:0]       r_count, n_count;
    logic [VALUE_WIDTH-1:0] r_last, n_last;
    logic                   r_first, n_first;
    logic [PEND_N-1:0]      r_pending, n_pending;
    logic                   r_status, n_status;
    logic [CAP_W-1:0]       r_rd_idx, n_rd_idx;
    logic                   r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]       r_rd_tag, n_rd_tag;
    logic                   r_strobe, n_strobe;
    logic                   r_out_status, n_out_status;
    logic                   r_out_served, n_out_served;
    logic [ID_W-1:0]        r_out_owner, n_out_owner;
    logic [VALUE_WIDTH-1:0] r_out_value, n_out_value;

    logic [WORD_W-1:0]      mem [BOARD_DEPTH];
    logic [WORD_W-1:0]      r_rdata;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [WORD_W-1:0]      wr_data;

    t_sel_ctl               sel_ctl;
    logic [IDX_W-1:0]       best_index;
    logic [VALUE_WIDTH-1:0] best_value;
    logic [ID_W-1:0]        best_owner;

    logic [CFG_W-1:0]       cap_clamp;
    logic [CFG_W-1:0]       cap_live;
    logic                   serve_ok;
    logic [CNT_W-1:0]       cfg_req;

    nrs_select #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .ID_W        (ID_W),
        .IDX_W       (IDX_W)
    ) u_select (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (sel_ctl),
        .i_value      (r_rdata[VALUE_WIDTH-1:0]),
        .i_owner      (r_rdata[WORD_W-1:VALUE_WIDTH]),
        .i_index      (r_rd_tag),
        .i_last       (r_last),
        .o_best_index (best_index),
        .o_best_value (best_value),
        .o_best_owner (best_owner)
    );

    // Live capacity is the clamped register value limited by the active requesters.
    always_comb begin
        if (r_cfg_cap == '0) begin
            cap_clamp = CFG_W'(1);
        end else if (r_cfg_cap > CAP_W'(BOARD_DEPTH)) begin
            cap_clamp = CFG_W'(BOARD_DEPTH);
        end else begin
            cap_clamp = CFG_W'(r_cfg_cap);
        end
        cap_live = (CFG_W'(r_active) < cap_clamp) ? CFG_W'(r_active) : cap_clamp;
        serve_ok = (cap_live != '0) && (r_count != '0) && (CFG_W'(r_count) >= cap_live);
        cfg_req  = i_cfg_data[CNT_W-1:0];
    end

    always_comb begin
        n_state      = r_state;
        n_cfg_cap    = r_cfg_cap;
        n_active     = r_active;
        n_count      = r_count;
        n_last       = r_last;
        n_first      = r_first;
        n_pending    = r_pending;
        n_status     = r_status;
        n_rd_idx     = r_rd_idx;
        n_rd_vld     = r_rd_vld;
        n_rd_tag     = r_rd_tag;
        n_strobe     = 1'b0;
        n_out_status = r_out_status;
        n_out_served = r_out_served;
        n_out_owner  = r_out_owner;
        n_out_value  = r_out_value;
        rd_addr      = r_rd_idx[IDX_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_count[IDX_W-1:0];
        wr_data      = {i_requester_id, i_request_value};
        sel_ctl      = '0;
        sel_ctl.first_mode = r_first;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_status = 1'b0;
                    if (i_cmd == CMD_POST) begin
                        if (r_pending[i_requester_id] || (r_count == CAP_W'(BOARD_DEPTH))) begin
                            n_status = 1'b1;
                        end else begin
                            wr_en                     = 1'b1;
                            n_count                   = r_count + CAP_W'(1);
                            n_pending[i_requester_id] = 1'b1;
                        end
                    end else if (r_active != '0) begin
                        n_active = r_active - CNT_W'(1);
                    end
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                sel_ctl.clear = 1'b1;
                if (serve_ok) begin
                    n_rd_idx = '0;
                    n_rd_vld = 1'b0;
                    n_state  = ST_SCAN;
                end else begin
                    n_strobe     = 1'b1;
                    n_out_status = r_status;
                    n_out_served = 1'b0;
                    n_out_owner  = '0;
                    n_out_value  = '0;
                    n_state      = ST_IDLE;
                end
            end
            ST_SCAN: begin
                sel_ctl.valid = r_rd_vld;
                n_rd_vld      = 1'b0;
                if (r_rd_idx < r_count) begin
                    n_rd_vld = 1'b1;
                    n_rd_tag = r_rd_idx[IDX_W-1:0];
                    n_rd_idx = r_rd_idx + CAP_W'(1);
                end else if (!r_rd_vld) begin
                    n_rd_idx = CAP_W'(best_index) + CAP_W'(1);
                    n_state  = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                n_rd_vld = 1'b0;
                if (r_rd_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = r_rd_tag - IDX_W'(1);
                    wr_data = r_rdata;
                end
                if (r_rd_idx < r_count) begin
                    n_rd_vld = 1'b1;
                    n_rd_tag = r_rd_idx[IDX_W-1:0];
                    n_rd_idx = r_rd_idx + CAP_W'(1);
                end else if (!r_rd_vld) begin
                    n_strobe              = 1'b1;
                    n_out_status          = r_status;
                    n_out_served          = 1'b1;
                    n_out_owner           = best_owner;
                    n_out_value           = best_value;
                    n_count               = r_count - CAP_W'(1);
                    n_pending[best_owner] = 1'b0;
                    n_last                = best_value;
                    n_first               = 1'b0;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BOARD_CAPACITY: begin
                    n_cfg_cap = i_cfg_data[CAP_W-1:0];
                end
                CFG_REQUESTER_COUNT: begin
                    n_active = (cfg_req > CNT_W'(MAX_REQUESTERS)) ? CNT_W'(MAX_REQUESTERS)
                                                                  : cfg_req;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg_cap <= CAP_W'(CAP_RESET);
            r_active  <= CNT_W'(ACT_RESET);
            r_count   <= '0;
            r_last    <= '0;
            r_first   <= 1'b1;
            r_pending <= '0;
            r_status  <= 1'b0;
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cfg_cap <= n_cfg_cap;
            r_active  <= n_active;
            r_count   <= n_count;
            r_last    <= n_last;
            r_first   <= n_first;
            r_pending <= n_pending;
            r_status  <= n_status;
            r_rd_idx  <= n_rd_idx;
            r_rd_vld  <= n_rd_vld;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_tag     <= n_rd_tag;
        r_out_status <= n_out_status;
        r_out_served <= n_out_served;
        r_out_owner  <= n_out_owner;
        r_out_value  <= n_out_value;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[rd_addr];
    end

    assign busy               = (r_state != ST_IDLE);
    assign o_result_strobe    = r_strobe;
    assign o_post_status      = r_out_status;
    assign o_served           = r_out_served;
    assign o_served_requester = r_out_owner;
    assign o_served_value     = r_out_value;

endmodule

// ===== tb/tb_nrs_checker.sv =====
module tb_nrs_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic                              i_cmd,
    input  logic [3:0]                        i_requester_id,
    input  logic [9:0]                        i_request_value,
    input  logic                              i_cfg_we,
    input  logic [nrs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [4:0]                        i_cfg_data,
    input  logic                              i_result_strobe,
    input  logic                              i_post_status,
    input  logic                              i_served,
    input  logic [3:0]                        i_served_requester,
    input  logic [9:0]                        i_served_value,
    output int                                o_pending,
    output int                                o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH   = nrs_pkg::DEF_BOARD_DEPTH;
    localparam int MAX_REQ = nrs_pkg::DEF_MAX_REQUESTERS;

    typedef struct packed {
        logic       rejected;
        logic       served;
        logic [3:0] owner;
        logic [9:0] position;
    } t_outcome;

    logic [9:0] board_pos   [DEPTH];
    logic [3:0] board_owner [DEPTH];
    int         board_fill;
    logic [9:0] last_pos;
    bit         none_served;
    int         live_reqs;
    logic [3:0] cap_setting;
    t_outcome   outcome_q [$];
    int         fails = 0;

    function automatic int pos_gap(logic [9:0] a, logic [9:0] b);
        int diff = int'(a) - int'(b);
        return (diff < 0) ? -diff : diff;
    endfunction

    // Applies one command word to the board and returns the result word it causes.
    function automatic t_outcome schedule_word(logic cmd, logic [3:0] id, logic [9:0] pos);
        t_outcome res = '0;
        bit       dup = 1'b0;
        int       cap;
        int       pick;
        int       best;
        int       d;
        if (cmd == nrs_pkg::CMD_POST) begin
            for (int i = 0; i < board_fill; i++) begin
                if (board_owner[i] == id) dup = 1'b1;
            end
            if (dup || board_fill >= DEPTH) begin
                res.rejected = 1'b1;
            end else begin
                board_pos[board_fill]   = pos;
                board_owner[board_fill] = id;
                board_fill++;
            end
        end else if (live_reqs > 0) begin
            live_reqs--;
        end
        cap = (cap_setting == 4'd0) ? 1 : int'(cap_setting);
        if (cap > DEPTH) cap = DEPTH;
        if (live_reqs < cap) cap = live_reqs;
        if (cap > 0 && board_fill > 0 && board_fill >= cap) begin
            pick = 0;
            best = none_served ? int'(board_pos[0]) : pos_gap(board_pos[0], last_pos);
            for (int i = 1; i < board_fill; i++) begin
                d = none_served ? int'(board_pos[i]) : pos_gap(board_pos[i], last_pos);
                if (d < best) begin
                    best = d;
                    pick = i;
                end
            end
            res.served   = 1'b1;
            res.owner    = board_owner[pick];
            res.position = board_pos[pick];
            last_pos     = board_pos[pick];
            none_served  = 1'b0;
            for (int i = pick; i < board_fill - 1; i++) begin
                board_pos[i]   = board_pos[i + 1];
                board_owner[i] = board_owner[i + 1];
            end
            board_fill--;
        end
        return res;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            board_fill  = 0;
            last_pos    = '0;
            none_served = 1'b1;
            cap_setting = 4'(nrs_pkg::CAP_RESET);
            live_reqs   = nrs_pkg::REQ_RESET;
            outcome_q.delete();
        end else begin
            if (i_result_strobe) begin
                if (outcome_q.size() == 0) begin
                    $error("Result word arrived with no word outstanding.");
                    fails++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("post_status", want.rejected, i_post_status);
                    check_field("served", want.served, i_served);
                    check_field("served_requester", want.owner, i_served_requester);
                    check_field("served_value", want.position, i_served_value);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == nrs_pkg::CFG_BOARD_CAPACITY) begin
                    cap_setting = i_cfg_data[3:0];
                end else if (i_cfg_index == nrs_pkg::CFG_REQUESTER_COUNT) begin
                    live_reqs = (int'(i_cfg_data) > MAX_REQ) ? MAX_REQ : int'(i_cfg_data);
                end
            end
            if (i_start && !i_busy) begin
                outcome_q = {outcome_q,
                             schedule_word(i_cmd, i_requester_id, i_request_value)};
            end
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/tb_nearest_request_scheduler.sv =====
module tb_nearest_request_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES     = 9;
    localparam int PHASE_LEN  = 95;
    localparam int IDLE_LIMIT = 1000;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          start           = 1'b0;
    logic                          busy;
    logic                          i_cmd           = nrs_pkg::CMD_POST;
    logic [3:0]                    i_requester_id  = '0;
    logic [9:0]                    i_request_value = '0;
    logic                          i_cfg_we        = 1'b0;
    logic [nrs_pkg::CFG_IDX_W-1:0] i_cfg_index     = nrs_pkg::CFG_BOARD_CAPACITY;
    logic [4:0]                    i_cfg_data      = '0;
    logic                          o_result_strobe;
    logic                          o_post_status;
    logic                          o_served;
    logic [3:0]                    o_served_requester;
    logic [9:0]                    o_served_value;

    int pending_words;
    int fail_count;
    int idle_cycles = 0;
    bit steady      = 1'b0;

    int phase_cap [PHASES] = '{8, 1, 15, 0, 5, 3, 8, 2, 4};
    int phase_req [PHASES] = '{16, 16, 31, 3, 1, 8, 17, 0, 4};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    nearest_request_scheduler u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cmd              (i_cmd),
        .i_requester_id     (i_requester_id),
        .i_request_value    (i_request_value),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_result_strobe    (o_result_strobe),
        .o_post_status      (o_post_status),
        .o_served           (o_served),
        .o_served_requester (o_served_requester),
        .o_served_value     (o_served_value)
    );

    tb_nrs_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_busy             (busy),
        .i_cmd              (i_cmd),
        .i_requester_id     (i_requester_id),
        .i_request_value    (i_request_value),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_result_strobe    (o_result_strobe),
        .i_post_status      (o_post_status),
        .i_served           (o_served),
        .i_served_requester (o_served_requester),
        .i_served_value     (o_served_value),
        .o_pending          (pending_words),
        .o_fail_count       (fail_count)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_word(logic cmd, logic [3:0] id, logic [9:0] pos);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_requester_id  <= id;
        i_request_value <= pos;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_words != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [nrs_pkg::CFG_IDX_W-1:0] idx, logic [4:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [9:0] draw_position();
        case ($urandom_range(0, 9))
            6, 7: return 10'($urandom_range(500, 507));
            8: return $urandom_range(0, 1) ? 10'd0 : 10'd1023;
            9: return 10'($urandom_range(1000, 1023));
            default: return 10'($urandom_range(0, 999));
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first serve takes the smallest value; later ones the nearest, ties to the oldest.
        send_word(nrs_pkg::CMD_POST, 4'd0, 10'd1023);
        send_word(nrs_pkg::CMD_POST, 4'd1, 10'd0);
        send_word(nrs_pkg::CMD_POST, 4'd1, 10'd5);
        send_word(nrs_pkg::CMD_POST, 4'd2, 10'd600);
        send_word(nrs_pkg::CMD_POST, 4'd3, 10'd600);
        send_word(nrs_pkg::CMD_POST, 4'd4, 10'd400);
        send_word(nrs_pkg::CMD_POST, 4'd5, 10'd200);
        // Finishes shrink the capacity down to zero, including one whose entry is pending.
        send_word(nrs_pkg::CMD_FINISH, 4'd3, 10'd777);
        send_word(nrs_pkg::CMD_FINISH, 4'd9, 10'd0);
        send_word(nrs_pkg::CMD_FINISH, 4'd9, 10'd1023);
        send_word(nrs_pkg::CMD_FINISH, 4'd15, 10'd0);
        send_word(nrs_pkg::CMD_FINISH, 4'd15, 10'd0);
        // With nobody active the board fills to its physical depth and then rejects posts.
        for (int i = 6; i < 14; i++) begin
            send_word(nrs_pkg::CMD_POST, 4'(i), 10'(i * 73));
        end
        send_word(nrs_pkg::CMD_POST, 4'd14, 10'd1000);
        send_word(nrs_pkg::CMD_POST, 4'd15, 10'd1);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(nrs_pkg::CFG_BOARD_CAPACITY, 5'(phase_cap[p]));
            write_reg(nrs_pkg::CFG_REQUESTER_COUNT, 5'(phase_req[p]));
            for (int n = 0; n < PHASE_LEN; n++) begin
                if ($urandom_range(0, 39) == 0) settle();
                if ($urandom_range(0, 11) == 0) steady = !steady;
                send_word(($urandom_range(0, 23) == 0) ? nrs_pkg::CMD_FINISH
                                                        : nrs_pkg::CMD_POST,
                          4'($urandom_range(0, 15)), draw_position());
            end
        end

        settle();
        repeat (25) @(posedge i_clk);
        if (fail_count == 0 && pending_words == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== nearest_request_scheduler.f =====
rtl/nrs_pkg.sv
rtl/nrs_select.sv
rtl/nearest_request_scheduler.sv
tb/tb_nrs_checker.sv
tb/tb_nearest_request_scheduler.sv
